/* design/vpqa_pkg.sv */
// ----------------------------------------------------------------------------
// vpqa_pkg
// Shared widths, term count and saturation bounds for the plane quadric
// accumulator.
// ----------------------------------------------------------------------------
package vpqa_pkg;

	localparam int CoordW  = 24;
	localparam int NumTerm = 10;
	localparam int AccW    = 64;
	localparam int MulW    = 33;
	localparam int ProdW   = 2 * MulW;

	typedef logic signed [CoordW-1:0]  coord_t;
	typedef logic signed [AccW-1:0]    acc_t;
	typedef logic signed [MulW-1:0]    mul_op_t;
	typedef logic signed [ProdW-1:0]   prod_t;

	// root/divide unit control
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [61:0] rad;
		logic [29:0] num;
		logic [30:0] den;
	} rdu_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] res;
	} rdu_rsp_t;

	// lower clamp for each accumulator
	function automatic acc_t term_lo(input logic [3:0] k);
		acc_t v;
		v = '0;
		case (k)
			4'd1, 4'd2, 4'd5: v = -(acc_t'(1) <<< 38);
			4'd3, 4'd6, 4'd8: v = -(acc_t'(1) <<< 50);
			default:          v = '0;
		endcase
		return v;
	endfunction

	// upper clamp for each accumulator
	function automatic acc_t term_hi(input logic [3:0] k);
		acc_t v;
		v = '0;
		case (k)
			4'd3, 4'd6, 4'd8: v = acc_t'(1) <<< 50;
			4'd9:             v = acc_t'(1) <<< 62;
			default:          v = acc_t'(1) <<< 38;
		endcase
		return v;
	endfunction

endpackage

/* design/vpqa_mul.sv */
// ----------------------------------------------------------------------------
// vpqa_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vpqa_mul (
	input  logic             clk,
	input  vpqa_pkg::mul_op_t a,
	input  vpqa_pkg::mul_op_t b,
	output vpqa_pkg::prod_t   p_q
);
	import vpqa_pkg::*;

	// register the product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

/* design/vpqa_rdu.sv */
// ----------------------------------------------------------------------------
// vpqa_rdu
// Iterative square root / restoring divide. One compare-subtract per cycle while busy,
// 31 result bits per operation.
// ----------------------------------------------------------------------------
module vpqa_rdu (
	input  logic              clk,
	input  logic              arst_n,
	input  vpqa_pkg::rdu_req_t req,
	output vpqa_pkg::rdu_rsp_t rsp
);
	import vpqa_pkg::*;

	logic        busy_q;
	logic        div_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [61:0] rad_q;
	logic [34:0] rem_q;
	logic [30:0] root_q;
	logic [30:0] den_q;
	logic [34:0] rem_n;
	logic [34:0] trial;
	logic        fit;

	// shared compare/subtract operands
	always_comb begin
		if (div_q) begin
			rem_n = {rem_q[33:0], rad_q[61]};
			trial = {4'd0, den_q};
		end else begin
			rem_n = {rem_q[32:0], rad_q[61:60]};
			trial = {2'd0, root_q, 2'b01};
		end
		fit = rem_n >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load on start, iterate while busy
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q  <= req.is_div;
			den_q  <= req.den;
			root_q <= '0;
			if (req.is_div) begin
				rem_q <= {6'd0, req.num[29:1]};
				rad_q <= {req.num[0], 61'd0};
			end else begin
				rem_q <= '0;
				rad_q <= req.rad;
			end
		end else if (busy_q) begin
			rad_q  <= div_q ? {rad_q[60:0], 1'b0} : {rad_q[59:0], 2'b00};
			rem_q  <= fit ? rem_n - trial : rem_n;
			root_q <= {root_q[29:0], fit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = root_q;

endmodule

/* design/vpqa_acc.sv */
// ----------------------------------------------------------------------------
// vpqa_acc
// Bank of ten saturating quadric accumulators, one addition per cycle.
// ----------------------------------------------------------------------------
module vpqa_acc (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clr,
	input  logic                                  add_en,
	input  logic [3:0]                            idx,
	input  vpqa_pkg::acc_t                        term,
	output logic [vpqa_pkg::NumTerm-1:0][vpqa_pkg::AccW-1:0] acc_q
);
	import vpqa_pkg::*;

	logic signed [AccW:0] sum;
	acc_t                 lo;
	acc_t                 hi;
	acc_t                 sat;

	// add and clamp to the term's range
	always_comb begin
		lo  = term_lo(idx);
		hi  = term_hi(idx);
		sum = $signed({acc_q[idx][AccW-1], acc_q[idx]}) + $signed({term[AccW-1], term});
		if (sum < $signed({lo[AccW-1], lo}))
			sat = lo;
		else if (sum > $signed({hi[AccW-1], hi}))
			sat = hi;
		else
			sat = sum[AccW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (add_en) begin
			acc_q[idx] <= sat;
		end
	end

endmodule

/* design/vertex_plane_quadric_accumulator.sv */
// ----------------------------------------------------------------------------
// vertex_plane_quadric_accumulator
// Per triangle: cross product, unit normal, plane offset and ten quadric
// terms through one shared multiplier and one root/divide unit; emits the
// summed quadric on the last triangle of a ring.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, ax..cz, last_of_ring | triangle in
//   out     | out_valid, out_stall, q_aa..q_dd         | summed quadric out
//
// Between one transfer and the next, a triangle goes through four root/divide
// operations (one root and three divides), multiplier sequencing and control,
// and the normal fit shift. A degenerate triangle goes from the fit to emit.
// in_stall is high until the block is idle; a result waiting on out_stall holds
// the block only when the next result is ready.
// Reset clears the accumulators and all control state.
// ----------------------------------------------------------------------------
module vertex_plane_quadric_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [23:0]  ax,
	input  logic signed [23:0]  ay,
	input  logic signed [23:0]  az,
	input  logic signed [23:0]  bx,
	input  logic signed [23:0]  by,
	input  logic signed [23:0]  bz,
	input  logic signed [23:0]  cx,
	input  logic signed [23:0]  cy,
	input  logic signed [23:0]  cz,
	input  logic                last_of_ring,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [38:0]         q_aa,
	output logic signed [39:0]  q_ab,
	output logic signed [39:0]  q_ac,
	output logic signed [51:0]  q_ad,
	output logic [38:0]         q_bb,
	output logic signed [39:0]  q_bc,
	output logic signed [51:0]  q_bd,
	output logic [38:0]         q_cc,
	output logic signed [51:0]  q_cd,
	output logic [62:0]         q_dd
);
	import vpqa_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CROSS = 4'd1;
	localparam logic [3:0] S_MAG   = 4'd2;
	localparam logic [3:0] S_FIT   = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_ROOT  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_DOT   = 4'd7;
	localparam logic [3:0] S_DSAT  = 4'd8;
	localparam logic [3:0] S_TERM  = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;

	logic [3:0]          st_q;
	logic [3:0]          cnt_q;
	coord_t              p_q [9];
	logic                last_q;
	logic signed [50:0]  x_q [3];
	logic [49:0]         mag_q [3];
	logic                neg_q [3];
	logic [61:0]         sumsq_q;
	logic [30:0]         len_q;
	logic signed [31:0]  n_q [3];
	logic signed [57:0]  dot_q;
	logic signed [32:0]  d_q;
	logic                out_valid_q;

	logic signed [24:0]  e [6];
	mul_op_t             ma;
	mul_op_t             mb;
	prod_t               prod;
	rdu_req_t            rreq;
	rdu_rsp_t            rrsp;
	logic [1:0]          div_sel;
	logic [3:0]          kidx;
	logic [1:0]          j2;
	logic [5:0]          tsh;
	logic [ProdW-1:0]    pmag;
	logic [ProdW-1:0]    pshr;
	acc_t                term;
	logic                acc_add;
	logic                acc_clr;
	logic [NumTerm-1:0][AccW-1:0] acc;
	logic [57:0]         dmag;
	logic [31:0]         dmag_s;
	logic [32:0]         dsat;

	// edge vectors from the latched triangle
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e[i]   = 25'(p_q[i])     - 25'(p_q[3 + i]);
			e[3+i] = 25'(p_q[6 + i]) - 25'(p_q[3 + i]);
		end
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_CROSS: begin
				case (cnt_q)
					4'd0: begin ma = MulW'(e[1]); mb = MulW'(e[5]); end
					4'd1: begin ma = MulW'(e[2]); mb = MulW'(e[4]); end
					4'd2: begin ma = MulW'(e[2]); mb = MulW'(e[3]); end
					4'd3: begin ma = MulW'(e[0]); mb = MulW'(e[5]); end
					4'd4: begin ma = MulW'(e[0]); mb = MulW'(e[4]); end
					4'd5: begin ma = MulW'(e[1]); mb = MulW'(e[3]); end
					default: ;
				endcase
			end
			S_SQ: begin
				if (cnt_q < 4'd3) begin
					ma = {3'd0, mag_q[cnt_q[1:0]][29:0]};
					mb = {3'd0, mag_q[cnt_q[1:0]][29:0]};
				end
			end
			S_DOT: begin
				if (cnt_q < 4'd3) begin
					ma = MulW'(n_q[cnt_q[1:0]]);
					mb = MulW'(p_q[4'd3 + {2'd0, cnt_q[1:0]}]);
				end
			end
			S_TERM: begin
				case (cnt_q)
					4'd0: begin ma = MulW'(n_q[0]); mb = MulW'(n_q[0]); end
					4'd1: begin ma = MulW'(n_q[0]); mb = MulW'(n_q[1]); end
					4'd2: begin ma = MulW'(n_q[0]); mb = MulW'(n_q[2]); end
					4'd3: begin ma = MulW'(n_q[0]); mb = d_q; end
					4'd4: begin ma = MulW'(n_q[1]); mb = MulW'(n_q[1]); end
					4'd5: begin ma = MulW'(n_q[1]); mb = MulW'(n_q[2]); end
					4'd6: begin ma = MulW'(n_q[1]); mb = d_q; end
					4'd7: begin ma = MulW'(n_q[2]); mb = MulW'(n_q[2]); end
					4'd8: begin ma = MulW'(n_q[2]); mb = d_q; end
					4'd9: begin ma = d_q;            mb = d_q; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	vpqa_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p_q (prod)
	);

	// quadric term: truncate the product toward zero
	always_comb begin
		kidx = cnt_q - 4'd1;
		j2   = kidx[2:1];
		case (kidx)
			4'd3, 4'd6, 4'd8: tsh = 6'd14;
			4'd9:             tsh = 6'd0;
			default:          tsh = 6'd28;
		endcase
		pmag = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
		pshr = pmag >> tsh;
		term = prod[ProdW-1] ? -acc_t'(pshr[AccW-1:0]) : acc_t'(pshr[AccW-1:0]);
		acc_add = (st_q == S_TERM) && (cnt_q != 4'd0);
	end

	// plane offset: negate, truncate and clamp the dot product
	always_comb begin
		dmag   = dot_q[57] ? 58'(-dot_q) : 58'(dot_q);
		dmag_s = dmag[57:26];
		dsat   = (dmag_s > 32'h8000_0000) ? 33'h0_8000_0000 : {1'b0, dmag_s};
	end

	// root/divide requests
	always_comb begin
		div_sel     = (st_q == S_ROOT) ? 2'd0 : cnt_q[1:0] + 2'd1;
		rreq.start  = 1'b0;
		rreq.is_div = (st_q != S_SQ);
		rreq.rad    = sumsq_q + {2'd0, prod[59:0]};
		rreq.num    = mag_q[div_sel][29:0];
		rreq.den    = (st_q == S_ROOT) ? rrsp.res : len_q;
		case (st_q)
			S_SQ:    rreq.start = (cnt_q == 4'd3);
			S_ROOT:  rreq.start = rrsp.done;
			S_DIV:   rreq.start = rrsp.done && (cnt_q < 4'd2);
			default: rreq.start = 1'b0;
		endcase
	end

	vpqa_rdu u_rdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	assign acc_clr = (st_q == S_EMIT) && last_q && !(out_valid_q && out_stall);

	vpqa_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (acc_clr),
		.add_en (acc_add),
		.idx    (kidx),
		.term   (term),
		.acc_q  (acc)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q  <= S_CROSS;
						cnt_q <= '0;
					end
				end
				S_CROSS: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd6)
						st_q <= S_MAG;
				end
				S_MAG: st_q <= S_FIT;
				S_FIT: begin
					if ((mag_q[0][49:30] | mag_q[1][49:30] | mag_q[2][49:30]) != '0) begin
						st_q <= S_FIT;
					end else if ((mag_q[0] | mag_q[1] | mag_q[2]) == '0) begin
						st_q <= S_EMIT;
					end else begin
						st_q  <= S_SQ;
						cnt_q <= '0;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3)
						st_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rrsp.done) begin
						st_q  <= S_DIV;
						cnt_q <= '0;
					end
				end
				S_DIV: begin
					if (rrsp.done) begin
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd2) begin
							st_q  <= S_DOT;
							cnt_q <= '0;
						end
					end
				end
				S_DOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3)
						st_q <= S_DSAT;
				end
				S_DSAT: begin
					st_q  <= S_TERM;
					cnt_q <= '0;
				end
				S_TERM: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd10)
						st_q <= S_EMIT;
				end
				S_EMIT: begin
					// on the last triangle, hold while the previous result still waits
					if (!last_q || !(out_valid_q && out_stall))
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result valid: raise on emit, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_clr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					p_q[0] <= ax; p_q[1] <= ay; p_q[2] <= az;
					p_q[3] <= bx; p_q[4] <= by; p_q[5] <= bz;
					p_q[6] <= cx; p_q[7] <= cy; p_q[8] <= cz;
					last_q <= last_of_ring;
				end
			end
			S_CROSS: begin
				if (cnt_q != 4'd0) begin
					if (!kidx[0])
						x_q[j2] <= prod[50:0];
					else
						x_q[j2] <= x_q[j2] - prod[50:0];
				end
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= x_q[i][50] ? 50'(-x_q[i]) : 50'(x_q[i]);
					neg_q[i] <= x_q[i][50];
				end
				sumsq_q <= '0;
			end
			S_FIT: begin
				if ((mag_q[0][49:30] | mag_q[1][49:30] | mag_q[2][49:30]) != '0) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end
			end
			S_SQ: begin
				if (cnt_q != 4'd0)
					sumsq_q <= sumsq_q + {2'd0, prod[59:0]};
			end
			S_ROOT: begin
				if (rrsp.done)
					len_q <= rrsp.res;
			end
			S_DIV: begin
				if (rrsp.done) begin
					n_q[cnt_q[1:0]] <= neg_q[cnt_q[1:0]] ? -$signed({1'b0, rrsp.res})
					                                     : $signed({1'b0, rrsp.res});
					dot_q <= '0;
				end
			end
			S_DOT: begin
				if (cnt_q != 4'd0)
					dot_q <= dot_q + prod[57:0];
			end
			S_DSAT: begin
				d_q <= dot_q[57] ? $signed(dsat) : -$signed(dsat);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (acc_clr) begin
			q_aa <= acc[0][38:0];
			q_ab <= acc[1][39:0];
			q_ac <= acc[2][39:0];
			q_ad <= acc[3][51:0];
			q_bb <= acc[4][38:0];
			q_bc <= acc[5][39:0];
			q_bd <= acc[6][51:0];
			q_cc <= acc[7][38:0];
			q_cd <= acc[8][51:0];
			q_dd <= acc[9][62:0];
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
